### sv/cosine_similarity_gate_defines.svh
// Assertion macros shared by the cosine similarity gate RTL.
`ifndef COSINE_SIMILARITY_GATE_DEFINES_SVH
`define COSINE_SIMILARITY_GATE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define CSG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CSG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/csg_pkg.sv
// Types, sizes and codes for the cosine similarity gate.
`default_nettype none

package csg_pkg;

    localparam int MAX_QUERIES = 16;
    localparam int MAX_DIM     = 256;

    // Sized limits used in comparisons
    localparam logic [4:0] MAXQ_C    = 5'(MAX_QUERIES);
    localparam logic [4:0] Q_SAT_C   = 5'(MAX_QUERIES + 1);
    localparam logic [8:0] MAXD_C    = 9'(MAX_DIM);
    localparam logic [8:0] POS_SAT_C = 9'(MAX_DIM + 1);

    // Result kinds (m_tuser)
    localparam logic [1:0] KIND_QUERY   = 2'd0;
    localparam logic [1:0] KIND_VERDICT = 2'd1;
    localparam logic [1:0] KIND_LOAD    = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_BASE  = 3'd1;
    localparam logic [2:0] ST_COUNT    = 3'd2;
    localparam logic [2:0] ST_DIM      = 3'd3;
    localparam logic [2:0] ST_OVERALL  = 3'd4;
    localparam logic [2:0] ST_EACH     = 3'd5;
    localparam logic [2:0] ST_UNEVEN   = 3'd6;
    localparam logic [2:0] ST_OVERFLOW = 3'd7;

    // Load fault codes
    localparam logic [1:0] FLT_NONE   = 2'd0;
    localparam logic [1:0] FLT_UNEVEN = 2'd1;
    localparam logic [1:0] FLT_OVER   = 2'd2;

    // Register selects (paddr[2])
    localparam logic REG_MIN_OVERALL = 1'b0;
    localparam logic REG_MIN_EACH    = 1'b1;

    localparam logic signed [15:0] SIM_MAX = 16'sd32767;
    localparam logic [31:0]        CNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_MUL,
        S_ACC,
        S_CK_END,
        S_PMUL,
        S_ROOT,
        S_UPD,
        S_PQ_OUT,
        S_VD,
        S_DIV,
        S_VD_OUT,
        S_LD_OUT
    } state_t;

endpackage

`default_nettype wire

### sv/cosine_similarity_gate.sv
// Cosine similarity gate: baseline bank store, per-vector similarity and set verdict.
//
//  channel  | dir | transfer contents
//  ---------+-----+-----------------------------------------------------------
//  s_*      | in  | one vector element, mode and set end in tuser, vector end in tlast
//  m_*      | out | one result, kind in tuser, last result of the item in tlast
//  APB      | in  | threshold registers at 0x0 (overall) and 0x4 (per query)
//
// An element passes through transfer, memory read, multiply and accumulate steps.
// A candidate vector end adds 4 multiply passes and 15 root steps;
// a candidate set end adds a 20-step divider; a load end adds a load outcome step.
// Results leave through a one-entry output register; a stalled m_tready holds the
// item sequencer only when a further result must be written.
// Baseline memories are not cleared after reset; no clearing pass is needed.
`default_nettype none

`include "cosine_similarity_gate_defines.svh"

module cosine_similarity_gate (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [15:0]  s_tdata,   // [15:0] sample_value
    input  wire logic         s_tlast,   // end_of_vector
    input  wire logic [1:0]   s_tuser,   // [0] mode, [1] end_of_set
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [3:0] query_index, [19:4] similarity, [35:20] overall_similarity,
    // [51:36] weakest_similarity, [55:52] weakest_index, [56] passed,
    // [59:57] status, [91:60] check_count, [123:92] failure_count, [127:124] zero
    output logic [127:0]      m_tdata,
    output logic              m_tlast,   // last
    output logic [1:0]        m_tuser,   // [1:0] result_kind
    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import csg_pkg::*;

    // ---------------------------------------------------------------- memories
    logic [15:0] store_mem [2*MAX_QUERIES*MAX_DIM];
    logic [8:0]  len_mem   [2*MAX_QUERIES];
    logic [38:0] nrm_mem   [2*MAX_QUERIES];

    logic signed [15:0] st_rdata_reg;
    logic [8:0]         len_rdata_reg;
    logic [38:0]        nrm_rdata_reg;

    // ---------------------------------------------------------------- state
    state_t state_reg, state_next;

    logic               act_bank_reg, act_bank_next;
    logic [4:0]         qcnt_reg [2];
    logic [4:0]         qcnt_next [2];
    logic [8:0]         len0_reg [2];
    logic [8:0]         len0_next [2];
    logic [8:0]         ld_pos_reg, ld_pos_next;
    logic [1:0]         ld_fault_reg, ld_fault_next;
    logic [38:0]        ld_norm_reg, ld_norm_next;

    logic [8:0]         ck_pos_reg, ck_pos_next;
    logic [4:0]         ck_q_reg, ck_q_next;
    logic signed [40:0] dot_reg, dot_next;
    logic [38:0]        cnorm_reg, cnorm_next;
    logic signed [20:0] sum_reg, sum_next;
    logic signed [15:0] min_reg, min_next;
    logic [3:0]         min_idx_reg, min_idx_next;
    logic               mism_reg, mism_next;
    logic [31:0]        cc_reg, cc_next;
    logic [31:0]        fc_reg, fc_next;

    logic signed [15:0] min_overall_reg, min_overall_next;
    logic signed [15:0] min_each_reg, min_each_next;

    // item under work
    logic               it_mode_reg;
    logic signed [15:0] it_smp_reg;
    logic               it_eov_reg;
    logic               it_eos_reg;

    // element products
    logic signed [31:0] pr_sb_reg;
    logic signed [31:0] pr_ss_reg;

    // similarity unit
    logic [1:0]         mc_reg, mc_next;
    logic [58:0]        macc_reg, macc_next;
    logic [77:0]        p_reg, p_next;
    logic [108:0]       r_reg, r_next;
    logic [108:0]       qs_reg, qs_next;
    logic [108:0]       ps_reg, ps_next;
    logic [14:0]        k_reg, k_next;
    logic [3:0]         bit_reg, bit_next;
    logic signed [15:0] sim_reg, sim_next;

    // mean divider
    logic [19:0]        dq_reg, dq_next;
    logic [4:0]         drem_reg, drem_next;
    logic [4:0]         dcnt_reg, dcnt_next;
    logic signed [15:0] ov_reg, ov_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [127:0]       out_data_reg, out_data_next;
    logic [1:0]         out_user_reg, out_user_next;
    logic               out_last_reg, out_last_next;

    // ---------------------------------------------------------------- shared signals
    logic         s_accept;
    logic         inact;
    logic [4:0]   ld_q;
    logic [4:0]   base;
    logic [4:0]   ck_row;
    logic [4:0]   ld_row;
    logic [12:0]  st_raddr;
    logic [12:0]  st_waddr;
    logic         st_we;
    logic         len_we;
    logic [8:0]   ld_len_v;
    logic [38:0]  ld_norm_v;
    logic [38:0]  ad;
    logic         match_v;
    logic         zero_norm;
    logic         good_v;
    logic [2:0]   vd_st;
    logic [38:0]  mul_x;
    logic [38:0]  mul_src;
    logic [19:0]  mul_y;
    logic [58:0]  mul_prod;
    logic [79:0]  mul_full;
    logic [109:0] root_diff;
    logic [20:0]  sum_abs;
    logic [5:0]   div_t;
    logic         cfg_wr;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign inact    = ~act_bank_reg;
    assign ld_q     = qcnt_reg[inact];
    assign base     = qcnt_reg[act_bank_reg];
    assign ck_row   = {act_bank_reg, ck_q_reg[3:0]};
    assign ld_row   = {inact, ld_q[3:0]};
    assign st_raddr = {ck_row, ck_pos_reg[7:0]};
    assign st_waddr = {ld_row, ld_pos_reg[7:0]};
    assign ad       = dot_reg[40] ? 39'(-dot_reg) : dot_reg[38:0];
    assign match_v  = (ck_q_reg < base) && (ck_pos_reg == len_rdata_reg);
    assign zero_norm = (nrm_rdata_reg == 39'd0) || (cnorm_reg == 39'd0);
    assign good_v   = (base != 5'd0) && (ck_q_reg == base) && !mism_reg;
    assign sum_abs  = sum_reg[20] ? 21'(-sum_reg) : 21'(sum_reg);
    assign div_t    = {drem_reg, dq_reg[19]};
    assign cfg_wr   = psel && penable && pwrite && pready;

    // shared multiplier for the norm product and the squared dot
    assign mul_x    = mc_reg[1] ? ad : nrm_rdata_reg;
    assign mul_src  = mc_reg[1] ? ad : cnorm_reg;
    assign mul_y    = mc_reg[0] ? {1'b0, mul_src[38:20]} : mul_src[19:0];
    assign mul_prod = 59'(mul_x * mul_y);
    assign mul_full = mc_reg[0] ? ({21'd0, macc_reg} + ({21'd0, mul_prod} << 20))
                                : {21'd0, mul_prod};

    // one root step: R - Q*2^(b+1) - P*2^(2b)
    assign root_diff = {1'b0, r_reg} - {1'b0, qs_reg} - {1'b0, ps_reg};

    // verdict status
    always_comb
    begin
        if (base == 5'd0)
            vd_st = ST_NO_BASE;
        else if (ck_q_reg != base)
            vd_st = ST_COUNT;
        else if (mism_reg)
            vd_st = ST_DIM;
        else if (ov_reg < min_overall_reg)
            vd_st = ST_OVERALL;
        else if ((min_each_reg > 16'sd0) && (min_reg < min_each_reg))
            vd_st = ST_EACH;
        else
            vd_st = ST_OK;
    end

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_accept) state_next = S_RD;
            S_RD:     state_next = S_MUL;
            S_MUL:    state_next = S_ACC;
            S_ACC:
            begin
                if (!it_mode_reg)
                    state_next = it_eos_reg ? S_LD_OUT : S_IDLE;
                else
                    state_next = it_eov_reg ? S_CK_END : S_IDLE;
            end
            S_CK_END:
            begin
                if (match_v)
                    state_next = zero_norm ? S_UPD : S_PMUL;
                else
                    state_next = S_PQ_OUT;
            end
            S_PMUL:   if (mc_reg == 2'd3) state_next = S_ROOT;
            S_ROOT:   if (bit_reg == 4'd0) state_next = S_UPD;
            S_UPD:    state_next = S_PQ_OUT;
            S_PQ_OUT: if (!out_valid_reg) state_next = it_eos_reg ? S_VD : S_IDLE;
            S_VD:     state_next = good_v ? S_DIV : S_VD_OUT;
            S_DIV:    if (dcnt_reg == 5'd0) state_next = S_VD_OUT;
            S_VD_OUT: if (!out_valid_reg) state_next = S_IDLE;
            S_LD_OUT: if (!out_valid_reg) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- datapath
    always_comb
    begin
        logic [1:0]  fault_v;
        logic [8:0]  pos_v;
        logic [14:0] k_v;
        logic        commit_v;
        logic        new_act;
        logic [2:0]  st_v;
        logic [31:0] cc_v;
        logic [31:0] fc_v;
        logic signed [15:0] wk_v;
        logic [3:0]  wi_v;
        logic signed [15:0] ovo_v;

        act_bank_next = act_bank_reg;
        qcnt_next     = qcnt_reg;
        len0_next     = len0_reg;
        ld_pos_next   = ld_pos_reg;
        ld_fault_next = ld_fault_reg;
        ld_norm_next  = ld_norm_reg;
        ck_pos_next   = ck_pos_reg;
        ck_q_next     = ck_q_reg;
        dot_next      = dot_reg;
        cnorm_next    = cnorm_reg;
        sum_next      = sum_reg;
        min_next      = min_reg;
        min_idx_next  = min_idx_reg;
        mism_next     = mism_reg;
        cc_next       = cc_reg;
        fc_next       = fc_reg;
        mc_next       = mc_reg;
        macc_next     = macc_reg;
        p_next        = p_reg;
        r_next        = r_reg;
        qs_next       = qs_reg;
        ps_next       = ps_reg;
        k_next        = k_reg;
        bit_next      = bit_reg;
        sim_next      = sim_reg;
        dq_next       = dq_reg;
        drem_next     = drem_reg;
        dcnt_next     = dcnt_reg;
        ov_next       = ov_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next = out_data_reg;
        out_user_next = out_user_reg;
        out_last_next = out_last_reg;
        st_we         = 1'b0;
        len_we        = 1'b0;
        ld_len_v      = ld_pos_reg;
        ld_norm_v     = ld_norm_reg;
        fault_v       = ld_fault_reg;
        pos_v         = ld_pos_reg;
        k_v           = k_reg;
        commit_v      = 1'b0;
        new_act       = act_bank_reg;
        st_v          = ST_OK;
        cc_v          = cc_reg;
        fc_v          = fc_reg;
        wk_v          = SIM_MAX;
        wi_v          = 4'd0;
        ovo_v         = 16'sd0;

        case (state_reg)
            // fold the element into the load or the running sums
            S_ACC:
            begin
                if (!it_mode_reg)
                begin
                    if ((ld_q >= MAXQ_C) || (ld_pos_reg >= MAXD_C))
                    begin
                        if (fault_v == FLT_NONE)
                            fault_v = FLT_OVER;
                    end
                    else
                    begin
                        st_we     = 1'b1;
                        ld_norm_v = ((ld_pos_reg == 9'd0) ? 39'd0 : ld_norm_reg)
                                    + {7'd0, pr_ss_reg};
                        pos_v     = ld_pos_reg + 9'd1;
                    end
                    ld_len_v = pos_v;
                    if (it_eov_reg)
                    begin
                        if (ld_q < MAXQ_C)
                        begin
                            len_we = 1'b1;
                            if ((ld_q != 5'd0) && (pos_v != len0_reg[inact])
                                && (fault_v == FLT_NONE))
                                fault_v = FLT_UNEVEN;
                            if (ld_q == 5'd0)
                                len0_next[inact] = pos_v;
                            qcnt_next[inact] = ld_q + 5'd1;
                        end
                        pos_v = 9'd0;
                    end
                    ld_pos_next   = pos_v;
                    ld_norm_next  = ld_norm_v;
                    ld_fault_next = fault_v;
                end
                else
                begin
                    if ((ck_q_reg < base) && (ck_pos_reg < len_rdata_reg)
                        && (ck_pos_reg < MAXD_C))
                    begin
                        dot_next   = dot_reg + {{9{pr_sb_reg[31]}}, pr_sb_reg};
                        cnorm_next = cnorm_reg + {7'd0, pr_ss_reg};
                    end
                    if (ck_pos_reg < POS_SAT_C)
                        ck_pos_next = ck_pos_reg + 9'd1;
                end
            end

            // vector end: length check, set up the similarity unit
            S_CK_END:
            begin
                sim_next = 16'sd0;
                mc_next  = 2'd0;
                if ((ck_q_reg < base) && !match_v)
                    mism_next = 1'b1;
            end

            // norm product then squared dot, two partial products each
            S_PMUL:
            begin
                mc_next = mc_reg + 2'd1;
                if (mc_reg == 2'd1)
                    p_next = mul_full[77:0];
                if (mc_reg == 2'd3)
                begin
                    r_next   = {1'b0, mul_full[77:0], 30'd0};
                    qs_next  = 109'd0;
                    ps_next  = {3'd0, p_reg, 28'd0};
                    k_next   = 15'd0;
                    bit_next = 4'd14;
                end
                else
                    macc_next = mul_full[58:0];
            end

            // restoring root/quotient search, one bit a cycle
            S_ROOT:
            begin
                if (!root_diff[109])
                begin
                    r_next  = root_diff[108:0];
                    k_v     = k_reg | (15'd1 << bit_reg);
                    qs_next = (qs_reg >> 1) + ps_reg;
                end
                else
                    qs_next = qs_reg >> 1;
                ps_next  = ps_reg >> 2;
                k_next   = k_v;
                bit_next = bit_reg - 4'd1;
                sim_next = dot_reg[40] ? -$signed({1'b0, k_v}) : $signed({1'b0, k_v});
            end

            // running sum and strict minimum
            S_UPD:
            begin
                if (!mism_reg)
                begin
                    sum_next = sum_reg + {{5{sim_reg[15]}}, sim_reg};
                    if (sim_reg < min_reg)
                    begin
                        min_next     = sim_reg;
                        min_idx_next = ck_q_reg[3:0];
                    end
                end
            end

            // per-query result
            S_PQ_OUT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_user_next  = KIND_QUERY;
                    out_last_next  = !it_eos_reg;
                    out_data_next  = {4'd0, fc_reg, cc_reg, ST_OK, 1'b0, 4'd0,
                                      16'd0, 16'd0, sim_reg, ck_q_reg[3:0]};
                    if (ck_q_reg < Q_SAT_C)
                        ck_q_next = ck_q_reg + 5'd1;
                    ck_pos_next = 9'd0;
                    dot_next    = 41'sd0;
                    cnorm_next  = 39'd0;
                end
            end

            // set end: start the mean divider if needed
            S_VD:
            begin
                ov_next   = 16'sd0;
                dq_next   = sum_abs[19:0];
                drem_next = 5'd0;
                dcnt_next = 5'd19;
            end

            S_DIV:
            begin
                if (div_t >= {1'b0, base})
                begin
                    drem_next = 5'(div_t - {1'b0, base});
                    dq_next   = {dq_reg[18:0], 1'b1};
                end
                else
                begin
                    drem_next = div_t[4:0];
                    dq_next   = {dq_reg[18:0], 1'b0};
                end
                dcnt_next = dcnt_reg - 5'd1;
                if (dcnt_reg == 5'd0)
                    ov_next = sum_reg[20] ? -$signed(dq_next[15:0])
                                          : $signed(dq_next[15:0]);
            end

            // verdict result, counters, check state cleared
            S_VD_OUT:
            begin
                st_v = vd_st;
                if ((st_v != ST_NO_BASE) && (st_v != ST_COUNT))
                begin
                    wk_v = min_reg;
                    wi_v = min_idx_reg;
                end
                if ((st_v != ST_NO_BASE) && (st_v != ST_COUNT) && (st_v != ST_DIM))
                    ovo_v = ov_reg;
                if (cc_reg != CNT_MAX)
                    cc_v = cc_reg + 32'd1;
                if ((st_v != ST_OK) && (fc_reg != CNT_MAX))
                    fc_v = fc_reg + 32'd1;
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_user_next  = KIND_VERDICT;
                    out_last_next  = 1'b1;
                    out_data_next  = {4'd0, fc_v, cc_v, st_v, (st_v == ST_OK), wi_v,
                                      wk_v, ovo_v, 16'd0, 4'd0};
                    cc_next      = cc_v;
                    fc_next      = fc_v;
                    ck_pos_next  = 9'd0;
                    ck_q_next    = 5'd0;
                    dot_next     = 41'sd0;
                    cnorm_next   = 39'd0;
                    sum_next     = 21'sd0;
                    min_next     = SIM_MAX;
                    min_idx_next = 4'd0;
                    mism_next    = 1'b0;
                end
            end

            // load outcome and bank switch
            S_LD_OUT:
            begin
                commit_v = (ld_fault_reg == FLT_NONE);
                if (commit_v)
                    st_v = ST_OK;
                else if (ld_fault_reg == FLT_UNEVEN)
                    st_v = ST_UNEVEN;
                else
                    st_v = ST_OVERFLOW;
                new_act = commit_v ? inact : act_bank_reg;
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_user_next  = KIND_LOAD;
                    out_last_next  = 1'b1;
                    out_data_next  = {4'd0, fc_reg, cc_reg, st_v, commit_v, 4'd0,
                                      16'd0, 16'd0, 16'd0, 4'd0};
                    act_bank_next      = new_act;
                    qcnt_next[~new_act] = 5'd0;
                    ld_fault_next      = FLT_NONE;
                end
            end

            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------- configuration
    always_comb
    begin
        min_overall_next = min_overall_reg;
        min_each_next    = min_each_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_MIN_OVERALL: min_overall_next = $signed(pwdata[15:0]);
                REG_MIN_EACH:    min_each_next    = $signed(pwdata[15:0]);
                default:         min_overall_next = min_overall_reg;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MIN_EACH) ? {16'd0, min_each_reg}
                                               : {16'd0, min_overall_reg};

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            act_bank_reg    <= 1'b0;
            qcnt_reg[0]     <= 5'd0;
            qcnt_reg[1]     <= 5'd0;
            ld_pos_reg      <= 9'd0;
            ld_fault_reg    <= FLT_NONE;
            ck_pos_reg      <= 9'd0;
            ck_q_reg        <= 5'd0;
            dot_reg         <= 41'sd0;
            cnorm_reg       <= 39'd0;
            sum_reg         <= 21'sd0;
            min_reg         <= SIM_MAX;
            min_idx_reg     <= 4'd0;
            mism_reg        <= 1'b0;
            cc_reg          <= 32'd0;
            fc_reg          <= 32'd0;
            min_overall_reg <= 16'sd27853;
            min_each_reg    <= 16'sd0;
            out_valid_reg   <= 1'b0;
            mc_reg          <= 2'd0;
            bit_reg         <= 4'd0;
            dcnt_reg        <= 5'd0;
        end
        else
        begin
            state_reg       <= state_next;
            act_bank_reg    <= act_bank_next;
            qcnt_reg        <= qcnt_next;
            ld_pos_reg      <= ld_pos_next;
            ld_fault_reg    <= ld_fault_next;
            ck_pos_reg      <= ck_pos_next;
            ck_q_reg        <= ck_q_next;
            dot_reg         <= dot_next;
            cnorm_reg       <= cnorm_next;
            sum_reg         <= sum_next;
            min_reg         <= min_next;
            min_idx_reg     <= min_idx_next;
            mism_reg        <= mism_next;
            cc_reg          <= cc_next;
            fc_reg          <= fc_next;
            min_overall_reg <= min_overall_next;
            min_each_reg    <= min_each_next;
            out_valid_reg   <= out_valid_next;
            mc_reg          <= mc_next;
            bit_reg         <= bit_next;
            dcnt_reg        <= dcnt_next;
        end
    end

    // ---------------------------------------------------------------- payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            it_mode_reg <= s_tuser[0];
            it_smp_reg  <= $signed(s_tdata);
            it_eov_reg  <= s_tlast || s_tuser[1];
            it_eos_reg  <= s_tuser[1];
        end
        if (state_reg == S_MUL)
        begin
            pr_sb_reg <= it_smp_reg * st_rdata_reg;
            pr_ss_reg <= it_smp_reg * it_smp_reg;
        end
        len0_reg     <= len0_next;
        ld_norm_reg  <= ld_norm_next;
        macc_reg     <= macc_next;
        p_reg        <= p_next;
        r_reg        <= r_next;
        qs_reg       <= qs_next;
        ps_reg       <= ps_next;
        k_reg        <= k_next;
        sim_reg      <= sim_next;
        dq_reg       <= dq_next;
        drem_reg     <= drem_next;
        ov_reg       <= ov_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    // ---------------------------------------------------------------- baseline memories
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            st_rdata_reg  <= $signed(store_mem[st_raddr]);
            len_rdata_reg <= len_mem[ck_row];
            nrm_rdata_reg <= nrm_mem[ck_row];
        end
        if (st_we)
            store_mem[st_waddr] <= it_smp_reg;
        if (len_we)
        begin
            len_mem[ld_row] <= ld_len_v;
            nrm_mem[ld_row] <= ld_norm_v;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // ---------------------------------------------------------------- assertions
    `CSG_ASSERT_NOW(a_qcnt_range, 1'b1, (qcnt_reg[0] <= MAXQ_C) && (qcnt_reg[1] <= MAXQ_C), "bank query count beyond limit")
    `CSG_ASSERT_NOW(a_pos_range, 1'b1, (ck_pos_reg <= POS_SAT_C) && (ld_pos_reg <= MAXD_C), "position beyond limit")
    `CSG_ASSERT_NOW(a_verdict_pass, m_tvalid && (m_tuser == KIND_VERDICT), (m_tdata[56] == (m_tdata[59:57] == ST_OK)) && m_tlast, "verdict pass flag disagrees with status")
    `CSG_ASSERT_NEXT(a_root_len, (state_reg == S_PMUL) && (mc_reg == 2'd3), (state_reg == S_ROOT) && (bit_reg == 4'd14), "root search not started at top bit")

endmodule

`default_nettype wire
